// ----- design/blsu_pkg.sv -----
// Package for the byte memory load/store unit.
// Holds the access codes, the stream field layout and the pipeline stage types.
// No dependencies.
package blsu_pkg;

   // Stream widths and field layout
   localparam int REQ_DATA_W    = 72;
   localparam int RSP_DATA_W    = 32;
   localparam int ADDR_W        = 32;
   localparam int WORD_W        = 32;
   localparam int REQ_SIZE_LSB  = 0;
   localparam int REQ_ZEXT_BIT  = 2;
   localparam int REQ_ADDR_LSB  = 3;
   localparam int REQ_SDATA_LSB = 35;
   localparam int LANES         = 4;

   // Command codes
   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_STORE = 1'b1;

   // Access size codes
   localparam logic [1:0] SIZE_BYTE = 2'd0;
   localparam logic [1:0] SIZE_HALF = 2'd1;
   localparam logic [1:0] SIZE_WORD = 2'd2;
   localparam logic [1:0] SIZE_NONE = 2'd3;

   // Item held in the input register, offset already relative to the base
   typedef struct packed {
      logic        cmd;
      logic [1:0]  size;
      logic        zext;
      logic        below;
      logic [31:0] offset;
      logic [31:0] store_data;
   } req_stage_type;

   // Item held alongside the registered memory read data
   typedef struct packed {
      logic       cmd;
      logic       bad;
      logic       zext;
      logic [1:0] size;
      logic [1:0] lane;
   } mem_stage_type;

   // Number of bytes an access size touches, zero for the unused code
   function automatic logic [2:0] size_bytes(input logic [1:0] size);
      logic [2:0] n;
      unique case (size)
         SIZE_BYTE: n = 3'd1;
         SIZE_HALF: n = 3'd2;
         SIZE_WORD: n = 3'd4;
         SIZE_NONE: n = 3'd0;
      endcase
      return n;
   endfunction

endpackage

// ----- design/byte_memory_load_store_unit.sv -----
// Byte-addressed little-endian data memory with load/store access stream.
// Depends on blsu_pkg (codes, field layout, stage types).
//
// Usage:
//   req_*  : one load or store per item. tuser carries the command, tdata the
//            size, extension flag, bus address and store data.
//   rsp_*  : one result per item, in order: load data in tdata, out-of-range
//            flag in tuser. Stores and dropped accesses answer with zero data.
//   csr_*  : writes the base address. Write only while no item is in flight.
// Timing:
//   Three register stages (input register, memory read register, result
//   register), which each item passes through in that order; one item per
//   cycle is sustained while rsp_tready is high. The memory is four
//   byte-wide banks, so any 1, 2 or 4 byte access, aligned or not, uses each
//   bank port once.
// Reset:
//   The base address returns to zero and the memory is cleared by a pass that
//   writes one row of four bytes per cycle, from row zero up to the last row.
//   req_tready stays low until the pass is done.
// Stall:
//   When rsp_tready is low, the result register holds and the stages behind
//   it keep filling; req_tready drops only once every stage is occupied.
module byte_memory_load_store_unit #(
   parameter int unsigned MEM_BYTES = 65536
) (
   input  logic                              clock,
   input  logic                              reset,
   // Request stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [1:0] access_size, [2] zero_extend, [34:3] address, [66:35] store_data
   input  logic [blsu_pkg::REQ_DATA_W-1:0]   req_tdata,
   // [0] cmd
   input  logic                              req_tuser,
   // Response stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [31:0] load_data
   output logic [blsu_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // [0] out_of_range
   output logic                              rsp_tuser,
   // Base address write port
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [blsu_pkg::ADDR_W-1:0]       csr_data
);
   import blsu_pkg::*;

   localparam int unsigned ROWS   = (MEM_BYTES + 3) / 4;
   localparam int unsigned ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam logic [32:0] MEM_LIMIT = 33'(MEM_BYTES);
   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

   // Control and payload registers
   logic [ADDR_W-1:0]    base_addr_ff, base_addr_in;
   logic                 clr_ff, clr_in;
   logic [ROW_W-1:0]     clr_row_ff, clr_row_in;
   logic                 s1_valid_ff, s1_valid_in;
   req_stage_type        s1_ff, s1_in;
   logic                 s2_valid_ff, s2_valid_in;
   mem_stage_type        s2_ff, s2_in;
   logic [7:0]           rd_ff [LANES];
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]    rsp_data_ff, rsp_data_in;
   logic                 rsp_oor_ff, rsp_oor_in;

   // Handshake and flow
   logic req_fire, s1_fire, s2_fire;
   logic s1_free, s2_free, s3_free;

   // Request field unpacking
   logic [ADDR_W-1:0] req_addr;

   // Address decode in the input stage
   logic [2:0]        s1_nbytes;
   logic [32:0]       s1_end;
   logic              s1_bad;
   logic [1:0]        s1_lane;
   logic [ROW_W-1:0]  s1_row;

   // Per-bank memory port controls
   logic [LANES-1:0]  wr_en;
   logic [7:0]        wr_byte [LANES];
   logic [ROW_W-1:0]  mem_row [LANES];
   logic              rd_en;

   // Result assembly
   logic [WORD_W-1:0] gathered;

   assign s3_free = !rsp_valid_ff || rsp_tready;
   assign s2_free = !s2_valid_ff || s3_free;
   assign s1_free = !s1_valid_ff || s2_free;

   assign req_tready = s1_free && !clr_ff;
   assign req_fire   = req_tvalid && req_tready;
   assign s1_fire    = s1_valid_ff && s2_free;
   assign s2_fire    = s2_valid_ff && s3_free;
   assign csr_ready  = 1'b1;

   assign req_addr = req_tdata[REQ_ADDR_LSB +: ADDR_W];

   // Input register: offset from the base is formed on the way in
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_in       = s1_ff;
      if (s1_free) begin
         s1_valid_in = req_fire;
      end
      if (req_fire) begin
         s1_in.cmd        = req_tuser;
         s1_in.size       = req_tdata[REQ_SIZE_LSB +: 2];
         s1_in.zext       = req_tdata[REQ_ZEXT_BIT];
         s1_in.below      = req_addr < base_addr_ff;
         s1_in.offset     = req_addr - base_addr_ff;
         s1_in.store_data = req_tdata[REQ_SDATA_LSB +: WORD_W];
      end
   end

   // Bounds check and bank mapping for the held item
   always_comb begin
      s1_nbytes = size_bytes(s1_ff.size);
      s1_end    = {1'b0, s1_ff.offset} + 33'(s1_nbytes);
      s1_bad    = (s1_ff.size == SIZE_NONE) || s1_ff.below || (s1_end > MEM_LIMIT);
      s1_lane   = s1_ff.offset[1:0];
      s1_row    = s1_ff.offset[ROW_W+1:2];
      rd_en     = s1_fire && (s1_ff.cmd == CMD_LOAD) && !s1_bad;
   end

   // Bank b holds byte (b - lane) of the access; banks below the start lane
   // wrap into the next row.
   always_comb begin
      logic [1:0] idx;
      for (int b = 0; b < LANES; b++) begin
         idx = 2'(b) - s1_lane;
         if (clr_ff) begin
            wr_en[b]   = 1'b1;
            wr_byte[b] = 8'h00;
            mem_row[b] = clr_row_ff;
         end else begin
            wr_en[b]   = s1_fire && (s1_ff.cmd == CMD_STORE) && !s1_bad
                         && ({1'b0, idx} < s1_nbytes);
            wr_byte[b] = s1_ff.store_data[8*idx +: 8];
            mem_row[b] = (2'(b) < s1_lane) ? s1_row + ROW_W'(1) : s1_row;
         end
      end
   end

   // Memory banks, one byte wide each
   for (genvar b = 0; b < LANES; b++) begin : g_bank
      logic [7:0] mem_ff [ROWS];
      always_ff @(posedge clock) begin
         if (wr_en[b]) begin
            mem_ff[mem_row[b]] <= wr_byte[b];
         end
         if (rd_en) begin
            rd_ff[b] <= mem_ff[mem_row[b]];
         end
      end
   end

   // Second stage bookkeeping
   always_comb begin
      s2_valid_in = s2_valid_ff;
      s2_in       = s2_ff;
      if (s2_free) begin
         s2_valid_in = s1_fire;
      end
      if (s1_fire) begin
         s2_in.cmd  = s1_ff.cmd;
         s2_in.bad  = s1_bad;
         s2_in.zext = s1_ff.zext;
         s2_in.size = s1_ff.size;
         s2_in.lane = s1_lane;
      end
   end

   // Rotate bank bytes back into access order, then extend
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         gathered[8*i +: 8] = rd_ff[2'(s2_ff.lane + 2'(i))];
      end
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_oor_in   = rsp_oor_ff;
      if (s3_free) begin
         rsp_valid_in = s2_fire;
      end
      if (s2_fire) begin
         rsp_oor_in = s2_ff.bad;
         if (s2_ff.bad || (s2_ff.cmd == CMD_STORE)) begin
            rsp_data_in = '0;
         end else begin
            unique case (s2_ff.size)
               SIZE_BYTE: rsp_data_in = {{24{!s2_ff.zext && gathered[7]}}, gathered[7:0]};
               SIZE_HALF: rsp_data_in = {{16{!s2_ff.zext && gathered[15]}}, gathered[15:0]};
               SIZE_WORD: rsp_data_in = gathered;
               SIZE_NONE: rsp_data_in = '0;
            endcase
         end
      end
   end

   // Clearing pass and base address register
   always_comb begin
      clr_in       = clr_ff;
      clr_row_in   = clr_row_ff;
      base_addr_in = base_addr_ff;
      if (clr_ff) begin
         clr_row_in = clr_row_ff + ROW_W'(1);
         if (clr_row_ff == LAST_ROW) begin
            clr_in = 1'b0;
         end
      end
      if (csr_valid && csr_ready) begin
         base_addr_in = csr_data;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= 1'b1;
         clr_row_ff   <= '0;
         base_addr_ff <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         clr_row_ff   <= clr_row_in;
         base_addr_ff <= base_addr_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      s1_ff       <= s1_in;
      s2_ff       <= s2_in;
      rsp_data_ff <= rsp_data_in;
      rsp_oor_ff  <= rsp_oor_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_oor_ff;

   // No item enters while the memory is being cleared
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      clr_ff |-> !req_tready)
      else $error("item accepted during clearing pass");

   // A dropped access never touches the memory
   a_bad_no_write: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && s1_bad && !clr_ff) |-> (wr_en == '0 && !rd_en))
      else $error("out-of-range access reached memory");

   // A dropped access or a store answers with zero data
   a_zero_data: assert property (@(posedge clock) disable iff (reset)
      $past(s2_fire && (s2_ff.bad || s2_ff.cmd == CMD_STORE)) |-> (rsp_data_ff == '0))
      else $error("nonzero data on store or dropped access");

   // An item leaving the input register lands in the read stage
   a_s1_to_s2: assert property (@(posedge clock) disable iff (reset)
      s1_fire |=> s2_valid_ff)
      else $error("item lost between input and read stage");

   // Nothing sits in the pipeline during the clearing pass
   a_empty_in_clear: assert property (@(posedge clock) disable iff (reset)
      clr_ff |-> (!s1_valid_ff && !s2_valid_ff))
      else $error("pipeline busy during clearing pass");

endmodule

// ----- tb/sv/tb_byte_memory_load_store_unit.sv -----
// Self-checking bench for byte_memory_load_store_unit: loads and stores against a
// byte-level shadow memory, under random gaps and stalls and several base addresses.
// Depends on blsu_pkg and the byte_memory_load_store_unit RTL.
module tb_byte_memory_load_store_unit;
   import blsu_pkg::*;

   localparam int CLK_PERIOD   = 10;
   localparam int RESET_CYCLES = 5;
   localparam int MEM_SIZE     = 65536;
   localparam int DRAIN_CYCLES = 6;
   // clearing pass after reset plus about 1100 items with long gaps, many times over
   localparam int CYCLE_LIMIT  = 750000;

   // One load/store request as the bench sees it
   typedef struct packed {
      logic        cmd;
      logic [1:0]  size;
      logic        zext;
      logic [31:0] address;
      logic [31:0] store_data;
   } mem_access_type;

   // One response
   typedef struct packed {
      logic [31:0] load_data;
      logic        out_of_range;
   } access_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [ADDR_W-1:0]     csr_data = '0;

   // Shadow of the memory contents and the base register
   bit [7:0]              shadow_mem [MEM_SIZE];
   logic [31:0]           shadow_base = '0;

   mem_access_type        pending_accesses [$];
   access_result_type     expected_results [$];
   mem_access_type        req_item;
   logic [REQ_DATA_W-1:0] req_word;
   access_result_type     due_result;
   int unsigned           queued_count = 0;
   int unsigned           accepted_count = 0;
   int unsigned           error_count = 0;
   int unsigned           cycle_count = 0;
   int unsigned           req_gap = 0;
   int unsigned           rsp_hold = 0;
   bit                    req_steady = 1'b0;
   bit                    rsp_steady = 1'b0;

   byte_memory_load_store_unit #(.MEM_BYTES(MEM_SIZE)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Performs one access on the shadow memory and returns the response it must give
   function automatic access_result_type apply_access(input mem_access_type a);
      access_result_type r;
      int unsigned    nbytes;
      logic [31:0]    offset;
      logic [32:0]    span_end;
      r = '0;
      case (a.size)
         SIZE_BYTE: nbytes = 1;
         SIZE_HALF: nbytes = 2;
         SIZE_WORD: nbytes = 4;
         default:   nbytes = 0;
      endcase
      offset   = a.address - shadow_base;
      span_end = {1'b0, offset} + 33'(nbytes);
      // unused size code, below the base (no wrap), or running past the end
      r.out_of_range = (a.size == SIZE_NONE) || (a.address < shadow_base) ||
                       (span_end > MEM_SIZE);
      if (!r.out_of_range) begin
         for (int i = 0; i < nbytes; i++) begin
            if (a.cmd == CMD_STORE) begin
               shadow_mem[offset + i] = a.store_data[8*i +: 8];
            end else begin
               r.load_data[8*i +: 8] = shadow_mem[offset + i];
            end
         end
         // word loads ignore the extension flag
         if (a.cmd == CMD_LOAD && !a.zext) begin
            if (a.size == SIZE_BYTE) begin
               r.load_data[31:8] = {24{r.load_data[7]}};
            end else if (a.size == SIZE_HALF) begin
               r.load_data[31:16] = {16{r.load_data[15]}};
            end
         end
      end
      return r;
   endfunction

   // Idle length: mostly none or short, now and then long
   function automatic int unsigned idle_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      else if (r < 85) return $urandom_range(1, 3);
      else if (r < 97) return $urandom_range(4, 12);
      else return $urandom_range(20, 60);
   endfunction

   // Random access aimed mostly inside the window that starts at base
   function automatic mem_access_type random_access(input logic [31:0] base);
      mem_access_type a;
      int unsigned pick;
      int unsigned offset;
      a.cmd        = $urandom_range(0, 1) ? CMD_STORE : CMD_LOAD;
      a.size       = ($urandom_range(0, 19) == 0) ? SIZE_NONE :
                     2'($urandom_range(SIZE_BYTE, SIZE_WORD));
      a.zext       = 1'($urandom_range(0, 1));
      a.store_data = $urandom();
      pick         = $urandom_range(0, 99);
      if (pick < 40) offset = $urandom_range(0, 63);
      else if (pick < 55) offset = MEM_SIZE - 1 - $urandom_range(0, 63);
      else offset = $urandom_range(0, MEM_SIZE - 1);
      if (pick < 70) begin
         a.address = base + offset;
      end else if (pick < 85) begin
         // straddle the low or the high edge of the window
         a.address = ($urandom_range(0, 1) ? base + MEM_SIZE : base) - $urandom_range(0, 4);
      end else begin
         a.address = $urandom();
      end
      return a;
   endfunction

   task automatic queue_access(input logic cmd, input logic [1:0] size, input logic zext,
                               input logic [31:0] address, input logic [31:0] store_data);
      mem_access_type a;
      a.cmd        = cmd;
      a.size       = size;
      a.zext       = zext;
      a.address    = address;
      a.store_data = store_data;
      pending_accesses.push_back(a);
      queued_count++;
   endtask

   // Returns once every queued item is taken and answered, plus a short drain
   task automatic wait_until_idle();
      do @(posedge clock);
      while (accepted_count != queued_count || expected_results.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_base(input logic [31:0] value);
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid   <= 1'b0;
      shadow_base = value;
   endtask

   task automatic random_phase(input logic [31:0] base, input int unsigned count);
      mem_access_type a;
      write_base(base);
      repeat (count) begin
         a = random_access(base);
         queue_access(a.cmd, a.size, a.zext, a.address, a.store_data);
      end
      wait_until_idle();
   endtask

   // Request driver: expectation is computed when an item is first presented
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            accepted_count++;
         end
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_accesses.size() > 0) begin
               req_item = pending_accesses.pop_front();
               expected_results.push_back(apply_access(req_item));
               req_word = '0;
               req_word[REQ_SIZE_LSB +: 2]       = req_item.size;
               req_word[REQ_ZEXT_BIT]            = req_item.zext;
               req_word[REQ_ADDR_LSB +: ADDR_W]  = req_item.address;
               req_word[REQ_SDATA_LSB +: WORD_W] = req_item.store_data;
               req_tdata  <= req_word;
               req_tuser  <= req_item.cmd;
               req_tvalid <= 1'b1;
               if ($urandom_range(0, 49) == 0) req_steady = !req_steady;
               req_gap = req_steady ? 0 : idle_gap();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response monitor and back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               $error("response with no outstanding item: load_data %h out_of_range %b",
                      rsp_tdata, rsp_tuser);
               error_count++;
            end else begin
               due_result = expected_results.pop_front();
               if (rsp_tdata !== due_result.load_data) begin
                  $error("load_data: expected %h, got %h", due_result.load_data, rsp_tdata);
                  error_count++;
               end
               if (rsp_tuser !== due_result.out_of_range) begin
                  $error("out_of_range: expected %b, got %b",
                         due_result.out_of_range, rsp_tuser);
                  error_count++;
               end
            end
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if ($urandom_range(0, 49) == 0) rsp_steady = !rsp_steady;
            rsp_hold = rsp_steady ? 0 : idle_gap();
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $error("timeout: %0d items queued, %0d taken, %0d responses outstanding",
                queued_count, accepted_count, expected_results.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Stimulus
   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed, at the reset base of zero
      queue_access(CMD_STORE, SIZE_WORD, 1'b0, 32'h0000_0000, 32'h8081_7F80);
      queue_access(CMD_LOAD,  SIZE_WORD, 1'b0, 32'h0000_0000, 32'h0);
      queue_access(CMD_LOAD,  SIZE_WORD, 1'b1, 32'h0000_0000, 32'h0);
      queue_access(CMD_LOAD,  SIZE_BYTE, 1'b0, 32'h0000_0000, 32'h0);
      queue_access(CMD_LOAD,  SIZE_BYTE, 1'b1, 32'h0000_0000, 32'h0);
      queue_access(CMD_LOAD,  SIZE_BYTE, 1'b0, 32'h0000_0001, 32'h0);
      queue_access(CMD_LOAD,  SIZE_HALF, 1'b0, 32'h0000_0002, 32'h0);
      queue_access(CMD_LOAD,  SIZE_HALF, 1'b1, 32'h0000_0002, 32'h0);
      queue_access(CMD_LOAD,  SIZE_HALF, 1'b0, 32'h0000_0001, 32'h0);
      // top of memory: last byte fits, wider accesses that overrun are dropped
      queue_access(CMD_STORE, SIZE_BYTE, 1'b0, 32'h0000_FFFF, 32'hAAAA_AA5A);
      queue_access(CMD_STORE, SIZE_HALF, 1'b0, 32'h0000_FFFF, 32'h0000_1111);
      queue_access(CMD_STORE, SIZE_WORD, 1'b0, 32'h0000_FFFD, 32'h2222_2222);
      queue_access(CMD_STORE, SIZE_WORD, 1'b0, 32'h0000_FFFC, 32'h1234_5678);
      queue_access(CMD_LOAD,  SIZE_WORD, 1'b0, 32'h0000_FFFC, 32'h0);
      queue_access(CMD_LOAD,  SIZE_BYTE, 1'b1, 32'h0000_FFFF, 32'h0);
      queue_access(CMD_LOAD,  SIZE_HALF, 1'b0, 32'h0000_FFFE, 32'h0);
      queue_access(CMD_LOAD,  SIZE_HALF, 1'b0, 32'h0000_FFFF, 32'h0);
      queue_access(CMD_LOAD,  SIZE_WORD, 1'b0, 32'h0001_0000, 32'h0);
      queue_access(CMD_LOAD,  SIZE_BYTE, 1'b0, 32'hFFFF_FFFF, 32'h0);
      // unused size code, for a store and a load; memory must be untouched
      queue_access(CMD_STORE, SIZE_NONE, 1'b0, 32'h0000_0000, 32'hFFFF_FFFF);
      queue_access(CMD_LOAD,  SIZE_NONE, 1'b0, 32'h0000_0000, 32'h0);
      queue_access(CMD_LOAD,  SIZE_WORD, 1'b0, 32'h0000_0000, 32'h0);
      // unaligned store with the extension flag set, then a load with store data set
      queue_access(CMD_STORE, SIZE_HALF, 1'b1, 32'h0000_1001, 32'hFFFF_C3A5);
      queue_access(CMD_LOAD,  SIZE_WORD, 1'b0, 32'h0000_1000, 32'hFFFF_FFFF);
      wait_until_idle();

      // Random phases over several base addresses, extremes included
      random_phase(32'h0000_0000, 220);
      random_phase(32'h0001_0000, 200);
      random_phase(32'hFFFF_0000, 200);
      random_phase(32'hFFFF_FFFF, 60);
      random_phase(32'h8000_0001, 200);
      random_phase($urandom(), 200);

      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
